### hdl/uarc_pkg.sv
// Shared types, constants and helpers for the unsigned-to-ASCII radix converter.
package uarc_pkg;

    localparam int VALUE_W = 32;
    localparam int PLACE_W = 5;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [1:0] CMD_DEC = 2'd0;
    localparam logic [1:0] CMD_HEX = 2'd1;
    localparam logic [1:0] CMD_BIN = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    // Maps one digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_RADIX)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_UPPER + CHAR_W'(d - DEC_RADIX);
        end
        return c;
    endfunction

endpackage

### hdl/uarc_cell.sv
// One digit cell of the converter chain: load, BCD add-3-and-shift, or digit shift.
module uarc_cell
    import uarc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [DIGIT_W-1:0] load_digit,
    input  logic               carry_in,
    input  logic [DIGIT_W-1:0] lower_digit,
    output logic [DIGIT_W-1:0] digit,
    output logic               carry_out
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // A BCD digit of five or more overflows on the coming doubling, so add three first.
    assign adj       = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = lower_digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### hdl/unsigned_to_ascii_radix_converter.sv
// Top level of the unsigned-to-ASCII radix converter: control and the digit cell chain.
// Per transaction at VALUE_BITS = 32, decimal runs 32 add-3-and-shift steps through the BCD
// cells, then 10 digit slots; hexadecimal and binary run only their digit slots, one per
// possible digit; an unused selector never raises busy. Each digit slot either drops a
// leading zero or emits one result, so the first result follows the last conversion step
// after the leading zeros. A new start is taken while busy is low. Results cannot be stalled.
// Reset (rst_n, asynchronous, active low) returns the block to idle with no result pending.
module unsigned_to_ascii_radix_converter
    import uarc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        cmd,
    input  logic [VALUE_W-1:0] value,
    output logic              result_valid,
    output logic [CHAR_W-1:0] ascii_char,
    output logic [PLACE_W-1:0] digit_place,
    output logic              last_digit
);

    // Only the low bits of the value take part; the port is never wider than 32 bits.
    localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    // One cell per possible digit; binary needs the most.
    localparam int NCELL    = EFF_BITS;
    // Decimal digits of the largest value: floor(n * log10(2)) + 1.
    localparam int NDEC     = ((EFF_BITS * 1233) >> 12) + 1;
    localparam int NHEX     = (EFF_BITS + 3) / 4;
    // Each radix keeps its most significant possible digit in the top cell.
    localparam int DEC_BASE = NCELL - NDEC;
    localparam int HEX_BASE = NCELL - NHEX;
    localparam int REM_W    = $clog2(NCELL + 1);
    localparam int CNT_W    = $clog2(EFF_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [EFF_BITS-1:0]   bin_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [REM_W-1:0]      rem_reg;
    logic                  lead_done_reg;
    logic [PLACE_W-1:0]    place_reg;
    logic                  result_valid_reg;
    logic [CHAR_W-1:0]     ascii_char_reg;
    logic [PLACE_W-1:0]    digit_place_reg;
    logic                  last_digit_reg;

    logic                  accept;
    logic                  cmd_known;
    cell_ctrl_t            ctrl;
    logic [NHEX*4-1:0]     hex_pad;
    logic [DIGIT_W-1:0]    cell_digit [NCELL];
    logic                  cell_carry [NCELL];
    logic [DIGIT_W-1:0]    top_digit;
    logic                  skip_zero;

    assign busy      = (state_reg != ST_IDLE);
    assign cmd_known = (cmd inside {CMD_DEC, CMD_HEX, CMD_BIN});
    assign accept    = start && !busy;

    // Cells load on a known command, run the BCD conversion for decimal, and shift
    // upward by one digit in every emit slot so the top cell always holds the next digit.
    assign ctrl.load   = accept && cmd_known;
    assign ctrl.dabble = (state_reg == ST_DABBLE);
    assign ctrl.shift  = (state_reg == ST_EMIT);

    assign hex_pad   = (NHEX * 4)'(value[EFF_BITS-1:0]);
    assign top_digit = cell_digit[NCELL-1];
    // Leading zeros are dropped, but the final digit slot always emits so zero shows as '0'.
    assign skip_zero = !lead_done_reg && (top_digit == '0) && (rem_reg > REM_W'(1));

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic [DIGIT_W-1:0] hex_d;
        logic [DIGIT_W-1:0] load_d;
        logic               cin;
        logic [DIGIT_W-1:0] low_d;

        if (i >= HEX_BASE)
        begin : g_hex
            assign hex_d = hex_pad[4*(i-HEX_BASE) +: 4];
        end
        else
        begin : g_nohex
            assign hex_d = '0;
        end

        always_comb
        begin
            case (cmd)
                CMD_HEX: load_d = hex_d;
                CMD_BIN: load_d = {{(DIGIT_W-1){1'b0}}, value[i]};
                default: load_d = '0;
            endcase
        end

        // The lowest decimal cell takes the binary bits; cells under it stay zero.
        if (i == DEC_BASE)
        begin : g_dec_in
            assign cin = bin_reg[EFF_BITS-1];
        end
        else if (i == 0)
        begin : g_bottom
            assign cin = 1'b0;
        end
        else
        begin : g_chain
            assign cin = cell_carry[i-1];
        end

        if (i == 0)
        begin : g_low0
            assign low_d = '0;
        end
        else
        begin : g_lown
            assign low_d = cell_digit[i-1];
        end

        uarc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .load_digit  (load_d),
            .carry_in    (cin),
            .lower_digit (low_d),
            .digit       (cell_digit[i]),
            .carry_out   (cell_carry[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bin_reg          <= '0;
            cnt_reg          <= '0;
            rem_reg          <= '0;
            lead_done_reg    <= 1'b0;
            place_reg        <= '0;
            result_valid_reg <= 1'b0;
            ascii_char_reg   <= '0;
            digit_place_reg  <= '0;
            last_digit_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            last_digit_reg   <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && cmd_known)
                    begin
                        bin_reg       <= value[EFF_BITS-1:0];
                        cnt_reg       <= CNT_W'(EFF_BITS);
                        lead_done_reg <= 1'b0;
                        place_reg     <= '0;
                        case (cmd)
                            CMD_DEC:
                            begin
                                rem_reg   <= REM_W'(NDEC);
                                state_reg <= ST_DABBLE;
                            end
                            CMD_HEX:
                            begin
                                rem_reg   <= REM_W'(NHEX);
                                state_reg <= ST_EMIT;
                            end
                            default:
                            begin
                                rem_reg   <= REM_W'(NCELL);
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_DABBLE:
                begin
                    bin_reg <= {bin_reg[EFF_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    rem_reg <= rem_reg - REM_W'(1);
                    if (!skip_zero)
                    begin
                        lead_done_reg    <= 1'b1;
                        result_valid_reg <= 1'b1;
                        ascii_char_reg   <= digit_char(top_digit);
                        digit_place_reg  <= place_reg;
                        last_digit_reg   <= (rem_reg == REM_W'(1));
                        place_reg        <= place_reg + PLACE_W'(1);
                    end
                    if (rem_reg == REM_W'(1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign ascii_char   = ascii_char_reg;
    assign digit_place  = digit_place_reg;
    assign last_digit   = last_digit_reg;

    // The final digit of a number closes the transaction.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_digit) |-> !busy)
        else $error("last digit shown while still busy");

    // Once digits start they come in consecutive cycles with consecutive places.
    a_digits_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_digit) |=>
            (result_valid && (digit_place == PLACE_W'($past(digit_place) + 1'b1))))
        else $error("gap or place jump inside a number");

    // An unused selector produces nothing.
    a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !cmd_known) |=> (!busy && !result_valid))
        else $error("unused selector started a conversion");

    // Every emitted character is a digit or an upper-case hex letter.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (((ascii_char >= 8'h30) && (ascii_char <= 8'h39)) ||
                          ((ascii_char >= 8'h41) && (ascii_char <= 8'h46))))
        else $error("character outside the digit set");

    // The first digit of a number never lags a leading zero: it is nonzero unless it is alone.
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (digit_place == '0) && !last_digit) |-> (ascii_char != 8'h30))
        else $error("leading zero emitted");

endmodule

### tb/tb_unsigned_to_ascii_radix_converter.sv
// Self-checking testbench for the unsigned-to-ASCII radix converter.
module tb_unsigned_to_ascii_radix_converter
    import uarc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The selector value that the block ignores: it takes the transaction and emits nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycles without any accepted transaction or result before the run is declared hung.
    // The slowest transaction is a decimal one behind the longest sender gap, so this leaves
    // a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;

    // Quiet cycles after the last expected digit, to catch stray results.
    localparam int DRAIN_CYCLES = 60;

    // Number of random conversions that produce digits.
    localparam int RANDOM_ITEMS = 450;

    // Mismatch lines beyond this count are still counted but not printed.
    localparam int PRINT_CAP = 200;

    typedef struct {
        logic [1:0]         sel;
        logic [VALUE_W-1:0] num;
    } conv_req_t;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic [PLACE_W-1:0] place;
        logic               final_flag;
    } digit_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         cmd = CMD_DEC;
    logic [VALUE_W-1:0] value = '0;
    logic               result_valid;
    logic [CHAR_W-1:0]  ascii_char;
    logic [PLACE_W-1:0] digit_place;
    logic               last_digit;

    // Conversions waiting to be driven, and the digits the block still owes us.
    conv_req_t  conv_requests[$];
    digit_rec_t expected_digits[$];

    conv_req_t  drv_req;
    digit_rec_t exp_digit;
    int         gap_left = 0;
    int         calm_items = 0;
    logic       req_taken = 1'b0;
    int         idle_cycles = 0;
    int         error_count = 0;

    unsigned_to_ascii_radix_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .value        (value),
        .result_valid (result_valid),
        .ascii_char   (ascii_char),
        .digit_place  (digit_place),
        .last_digit   (last_digit)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Reset is held low from the start and released on a falling edge, once per run.
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Prints one line per mismatch and keeps the tally used for the final verdict.
    task automatic report_mismatch(input string what);
        if (error_count < PRINT_CAP)
        begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
        error_count++;
    endtask

    // Works out the digit characters of one conversion, most significant first, and
    // queues them as the results the block has to emit. Leading zeros are never produced
    // because the division loop stops as soon as the quotient reaches zero, and a zero
    // value still yields its single '0' digit since the loop body runs at least once.
    function automatic void predict_digits(input logic [1:0] sel, input logic [VALUE_W-1:0] num);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] radix;
        logic [VALUE_W-1:0] d;
        logic [CHAR_W-1:0]  lsb_first[$];
        digit_rec_t         rec;
        int                 n;
        case (sel)
            CMD_DEC: radix = 10;
            CMD_HEX: radix = 16;
            CMD_BIN: radix = 2;
            default: return;
        endcase
        // VALUE_BITS is left at its default of 32, so the whole value field is converted.
        rest = num;
        do
        begin
            d = rest % radix;
            if (d < DEC_RADIX)
            begin
                lsb_first.push_back(CHAR_ZERO + CHAR_W'(d));
            end
            else
            begin
                lsb_first.push_back(CHAR_UPPER + CHAR_W'(d - DEC_RADIX));
            end
            rest = rest / radix;
        end
        while (rest != 0);
        n = lsb_first.size();
        for (int k = 0; k < n; k++)
        begin
            rec.ch         = lsb_first[n - 1 - k];
            rec.place      = PLACE_W'(k);
            rec.final_flag = (k == n - 1);
            expected_digits.push_back(rec);
        end
    endfunction

    // Sender gap after each transaction. Most gaps are zero or a few cycles, a few are
    // long enough to cover every phase of the slowest conversion, and now and then a run
    // of transactions goes back to back with no gap at all.
    function automatic int next_gap();
        int roll;
        if (calm_items > 0)
        begin
            calm_items--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_items = $urandom_range(10, 30);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 45);
    endfunction

    // Random values are shaped so that every digit count shows up: full 32-bit words,
    // words shifted down to a random length, tiny numbers, and numbers right at a power
    // of ten where the decimal digit count changes.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] pow10;
        int                 exp10;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return $urandom_range(0, 20);
            default:
            begin
                pow10 = 1;
                exp10 = $urandom_range(0, 9);
                repeat (exp10) pow10 = pow10 * 10;
                return pow10 + $urandom_range(0, 2) - 1;
            end
        endcase
    endfunction

    task automatic add_request(input logic [1:0] sel, input logic [VALUE_W-1:0] num);
        conv_req_t req;
        req.sel = sel;
        req.num = num;
        conv_requests.push_back(req);
    endtask

    // Acceptance tracking. A transaction is taken at a rising edge with start high and
    // busy low; its digits are predicted right here so they are queued before any of
    // them can appear. The same block keeps the watchdog's count of quiet cycles.
    always @(posedge clk)
    begin
        req_taken = rst_n && start && !busy;
        if (req_taken)
        begin
            predict_digits(cmd, value);
        end
        if (req_taken || (rst_n && result_valid))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    // Driver. Inputs move on the falling edge only. A presented transaction holds until
    // it is taken; after that the next one follows once its gap has run out.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_taken)
        begin
            // Still waiting for the block to take the current transaction.
        end
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (conv_requests.size() != 0)
        begin
            drv_req = conv_requests.pop_front();
            cmd      <= drv_req.sel;
            value    <= drv_req.num;
            start    <= 1'b1;
            gap_left <= next_gap();
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor. Each strobed digit is held up against the oldest expected one; the block
    // cannot be stalled, so every strobe is a result that has to match right away.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit: char %h place %0d last %0b",
                                          ascii_char, digit_place, last_digit));
            end
            else
            begin
                exp_digit = expected_digits.pop_front();
                if (ascii_char !== exp_digit.ch || digit_place !== exp_digit.place ||
                    last_digit !== exp_digit.final_flag)
                begin
                    report_mismatch($sformatf(
                        "digit mismatch: got char %h place %0d last %0b, want %h %0d %0b",
                        ascii_char, digit_place, last_digit,
                        exp_digit.ch, exp_digit.place, exp_digit.final_flag));
                end
            end
        end
    end

    // Ends the run when nothing has moved for too long.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("[%0t] ERROR: watchdog expired, digits still owed: %0d",
                 $realtime, expected_digits.size());
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and end of test.
    initial
    begin
        int produced;
        logic [1:0] sel;

        // Directed part: zero in every radix, the widest results (all ones, and a binary
        // number with only the top bit set), decimal digit-count boundaries, hex letters,
        // and the unused selector, which must produce no digits at all.
        add_request(CMD_DEC, 32'd0);
        add_request(CMD_DEC, 32'd1);
        add_request(CMD_DEC, 32'd9);
        add_request(CMD_DEC, 32'd10);
        add_request(CMD_DEC, 32'd99);
        add_request(CMD_DEC, 32'd100);
        add_request(CMD_DEC, 32'd999999999);
        add_request(CMD_DEC, 32'd1000000000);
        add_request(CMD_DEC, 32'hFFFF_FFFF);
        add_request(CMD_HEX, 32'd0);
        add_request(CMD_HEX, 32'd15);
        add_request(CMD_HEX, 32'd16);
        add_request(CMD_HEX, 32'hABCD_EF01);
        add_request(CMD_HEX, 32'h1000_0000);
        add_request(CMD_HEX, 32'hFFFF_FFFF);
        add_request(CMD_UNUSED, 32'd0);
        add_request(CMD_BIN, 32'd0);
        add_request(CMD_BIN, 32'd1);
        add_request(CMD_BIN, 32'd2);
        add_request(CMD_BIN, 32'h8000_0000);
        add_request(CMD_BIN, 32'h5555_5555);
        add_request(CMD_BIN, 32'hFFFF_FFFF);
        add_request(CMD_UNUSED, 32'hFFFF_FFFF);
        add_request(CMD_HEX, 32'hAAAA_AAAA);

        // Random part. The unused selector shows up now and then but does not count,
        // since the block does nothing with it.
        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                sel = CMD_UNUSED;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: sel = CMD_DEC;
                    1: sel = CMD_HEX;
                    default: sel = CMD_BIN;
                endcase
                produced++;
            end
            add_request(sel, random_value());
        end

        // Wait until everything is driven, taken and answered, then give the block time
        // to show any digit it should not have produced.
        while (conv_requests.size() != 0 || start || expected_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### unsigned_to_ascii_radix_converter.f
hdl/uarc_pkg.sv
hdl/uarc_cell.sv
hdl/unsigned_to_ascii_radix_converter.sv
tb/tb_unsigned_to_ascii_radix_converter.sv
